// ===== hdl/pfa_pkg.sv =====
// Package: shared constants, types and codes of the prime field ALU.
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int FIELD_BITS = 63;
  localparam int CNT_W      = $clog2(FIELD_BITS);
  localparam int CFG_IDX_W  = 1;

  localparam logic [FIELD_BITS-1:0] MODULUS_RST = FIELD_BITS'(64'd2305843009213693951);
  localparam logic [FIELD_BITS-1:0] FIELD_ONE   = FIELD_BITS'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT    = 1'b1;

  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_POW  = 3'd3,
    MODE_INV  = 3'd4,
    MODE_ROOT = 3'd5
  } mode_e;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_RED_A    = 12'b0000_0000_0010,
    S_RED_B    = 12'b0000_0000_0100,
    S_ARITH    = 12'b0000_0000_1000,
    S_MUL      = 12'b0000_0001_0000,
    S_POW      = 12'b0000_0010_0000,
    S_POW_MUL  = 12'b0000_0100_0000,
    S_POW_SQ   = 12'b0000_1000_0000,
    S_ADIC     = 12'b0001_0000_0000,
    S_ROOT_RED = 12'b0010_0000_0000,
    S_ROOT_SQ  = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_e;

  // Request to the shared modular multiplier
  typedef struct packed {
    logic                  start;
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic [FIELD_BITS-1:0] m;
  } mm_req_t;

endpackage

// ===== hdl/pfa_if.sv =====
// Interfaces: operation, result and configuration channels.
`timescale 1ns / 1ps
interface pfa_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     mode;
  logic [pfa_pkg::FIELD_BITS-1:0] operand_a;
  logic [pfa_pkg::FIELD_BITS-1:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface pfa_out_if;
  logic                           valid;
  logic                           ready;
  logic [pfa_pkg::FIELD_BITS-1:0] value;
  logic                           order_error;
  modport source (output valid, value, order_error, input ready);
  modport sink   (input valid, value, order_error, output ready);
endinterface

interface pfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pfa_pkg::CFG_IDX_W-1:0]  index;
  logic [pfa_pkg::FIELD_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pfa_mulmod.sv =====
// Bit-serial modular multiplier: one double-and-add step per cycle, multiplier MSB first.
`timescale 1ns / 1ps
module pfa_mulmod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfa_pkg::mm_req_t               req_i,
  output logic                           done_o,
  output logic [pfa_pkg::FIELD_BITS-1:0] res_o
);
  import pfa_pkg::*;

  logic [FIELD_BITS-1:0] r_q, x_q, y_q, m_q;
  logic [FIELD_BITS-1:0] r_step;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic [FIELD_BITS:0]   dbl, dbl_red, sum, sum_red;

  // r = 2r mod m, then r = r + x mod m when the multiplier bit is set
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum     = {1'b0, dbl_red[FIELD_BITS-1:0]} +
              (y_q[FIELD_BITS-1] ? {1'b0, x_q} : '0);
    sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
    r_step  = sum_red[FIELD_BITS-1:0];
  end

  // Step counter and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FIELD_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= '0;
      x_q <= req_i.x;
      y_q <= req_i.y;
      m_q <= req_i.m;
    end else if (busy_q) begin
      r_q <= r_step;
      y_q <= {y_q[FIELD_BITS-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

// ===== hdl/prime_field_alu_top.sv =====
// Top level: sequencer of the prime field ALU around one shared modular multiplier.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : one transaction per operation (mode, operand_a, operand_b).
//   out_ch : one transaction per operation (value, order_error), in order.
//   cfg_ch : writes modulus (index 0) or root_of_unity (index 1); always ready,
//            write only while no operation is in flight.
// One operation is in work at a time; in_ch.ready is high only when idle.
// Every modular multiply runs on the bit-serial multiplier as one pass
// (launch, 63 steps, collect). Each operand reduction costs one such pass.
//   add/subtract : two reduction passes, then the add
//   multiply     : two reduction passes, then one multiply pass
//   power        : one reduction pass, then per exponent bit one squaring
//                  pass, plus one multiply pass for each set bit
//   inverse      : same as power with exponent modulus-2
//   root         : trailing-zero scan of modulus-1 (one bit per cycle) plus
//                  a reduction pass of root_of_unity and one pass per squaring
// Modulus below two goes straight to the result with value 0.
// Result sits in an output register; a stalled receiver holds the block in
// its final state until the register frees up, while the next operation can
// already be accepted once the result is loaded.
// Reset: modulus = 2^61-1, root_of_unity = 0, no result pending.
module prime_field_alu_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfa_in_if.sink    in_ch,
  pfa_out_if.source out_ch,
  pfa_cfg_if.sink   cfg_ch
);
  import pfa_pkg::*;

  state_e                state_q, state_d;
  logic [FIELD_BITS-1:0] mod_q, root_q;
  logic [FIELD_BITS-1:0] a_q, a_d, b_q, b_d, val_q, val_d;
  logic [2:0]            mode_q, mode_d;
  logic                  err_q, err_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  launched_q, launched_d;
  logic                  out_valid_q, out_valid_d;
  logic [FIELD_BITS-1:0] out_val_q, out_val_d;
  logic                  out_err_q, out_err_d;
  mm_req_t               mm_req;
  logic                  mm_done;
  logic [FIELD_BITS-1:0] mm_res;
  logic [FIELD_BITS-1:0] addend;
  logic [FIELD_BITS:0]   asum, asum_red;

  pfa_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  assign in_ch.ready  = (state_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid       = out_valid_q;
  assign out_ch.value       = out_val_q;
  assign out_ch.order_error = out_err_q;

  // Add / subtract on reduced operands
  always_comb begin
    if (mode_q == MODE_SUB) begin
      addend = (b_q == '0) ? '0 : mod_q - b_q;
    end else begin
      addend = b_q;
    end
    asum     = {1'b0, a_q} + {1'b0, addend};
    asum_red = (asum >= {1'b0, mod_q}) ? asum - {1'b0, mod_q} : asum;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    val_d       = val_q;
    mode_d      = mode_q;
    err_d       = err_q;
    cnt_d       = cnt_q;
    launched_d  = launched_q;
    out_val_d   = out_val_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q;
    mm_req      = '0;
    mm_req.m    = mod_q;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_d = in_ch.mode;
          a_d    = in_ch.operand_a;
          b_d    = in_ch.operand_b;
          err_d  = 1'b0;
          val_d  = '0;
          cnt_d  = '0;
          if (mod_q < FIELD_BITS'(2)) begin
            state_d = S_DONE;
          end else begin
            case (in_ch.mode)
              MODE_ADD, MODE_SUB, MODE_MUL, MODE_POW, MODE_INV: state_d = S_RED_A;
              MODE_ROOT: begin
                a_d     = mod_q - FIELD_ONE;
                state_d = S_ADIC;
              end
              default: state_d = S_DONE;
            endcase
          end
        end
      end

      S_RED_A: begin
        mm_req.x = FIELD_ONE;
        mm_req.y = a_q;
        if (!launched_q) begin
          mm_req.start = 1'b1;
          launched_d   = 1'b1;
        end else if (mm_done) begin
          launched_d = 1'b0;
          a_d        = mm_res;
          case (mode_q)
            MODE_ADD, MODE_SUB, MODE_MUL: state_d = S_RED_B;
            MODE_POW: begin
              val_d   = FIELD_ONE;
              state_d = S_POW;
            end
            MODE_INV: begin
              if (mm_res == '0) begin
                val_d   = '0;
                state_d = S_DONE;
              end else begin
                b_d     = mod_q - FIELD_BITS'(2);
                val_d   = FIELD_ONE;
                state_d = S_POW;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_RED_B: begin
        mm_req.x = FIELD_ONE;
        mm_req.y = b_q;
        if (!launched_q) begin
          mm_req.start = 1'b1;
          launched_d   = 1'b1;
        end else if (mm_done) begin
          launched_d = 1'b0;
          b_d        = mm_res;
          state_d    = (mode_q == MODE_MUL) ? S_MUL : S_ARITH;
        end
      end

      S_ARITH: begin
        val_d   = asum_red[FIELD_BITS-1:0];
        state_d = S_DONE;
      end

      S_MUL: begin
        mm_req.x = a_q;
        mm_req.y = b_q;
        if (!launched_q) begin
          mm_req.start = 1'b1;
          launched_d   = 1'b1;
        end else if (mm_done) begin
          launched_d = 1'b0;
          val_d      = mm_res;
          state_d    = S_DONE;
        end
      end

      // Square-and-multiply, low exponent bit first: acc in val, base in a
      S_POW: begin
        if (b_q == '0) begin
          state_d = S_DONE;
        end else if (b_q[0]) begin
          state_d = S_POW_MUL;
        end else begin
          state_d = S_POW_SQ;
        end
      end

      S_POW_MUL: begin
        mm_req.x = val_q;
        mm_req.y = a_q;
        if (!launched_q) begin
          mm_req.start = 1'b1;
          launched_d   = 1'b1;
        end else if (mm_done) begin
          launched_d = 1'b0;
          val_d      = mm_res;
          state_d    = S_POW_SQ;
        end
      end

      S_POW_SQ: begin
        mm_req.x = a_q;
        mm_req.y = a_q;
        if (!launched_q) begin
          mm_req.start = 1'b1;
          launched_d   = 1'b1;
        end else if (mm_done) begin
          launched_d = 1'b0;
          a_d        = mm_res;
          b_d        = b_q >> 1;
          state_d    = S_POW;
        end
      end

      // Trailing zeros of modulus-1, one bit per cycle
      S_ADIC: begin
        if (!a_q[0]) begin
          a_d   = a_q >> 1;
          cnt_d = cnt_q + 1'b1;
        end else if (b_q > FIELD_BITS'(cnt_q)) begin
          err_d   = 1'b1;
          val_d   = '0;
          state_d = S_DONE;
        end else begin
          a_d     = root_q;
          cnt_d   = cnt_q - b_q[CNT_W-1:0];
          state_d = S_ROOT_RED;
        end
      end

      S_ROOT_RED: begin
        mm_req.x = FIELD_ONE;
        mm_req.y = a_q;
        if (!launched_q) begin
          mm_req.start = 1'b1;
          launched_d   = 1'b1;
        end else if (mm_done) begin
          launched_d = 1'b0;
          a_d        = mm_res;
          state_d    = S_ROOT_SQ;
        end
      end

      S_ROOT_SQ: begin
        mm_req.x = a_q;
        mm_req.y = a_q;
        if (cnt_q == '0) begin
          val_d   = a_q;
          state_d = S_DONE;
        end else if (!launched_q) begin
          mm_req.start = 1'b1;
          launched_d   = 1'b1;
        end else if (mm_done) begin
          launched_d = 1'b0;
          a_d        = mm_res;
          cnt_d      = cnt_q - 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = val_q;
          out_err_d   = err_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mod_q       <= MODULUS_RST;
      root_q      <= '0;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_MODULUS: mod_q  <= cfg_ch.data;
          CFG_ROOT:    root_q <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    val_q     <= val_d;
    mode_q    <= mode_d;
    err_q     <= err_d;
    cnt_q     <= cnt_d;
    out_val_q <= out_val_d;
    out_err_q <= out_err_d;
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench: self-checking random and directed test of the prime field ALU top level.
`timescale 1ns / 1ps
module tb_top;
  import pfa_pkg::*;

  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam bit [62:0]  ALL_ONES   = '1;

  // Expected-result store with its own field arithmetic, modulus and root
  class field_alu_scoreboard;
    typedef struct {
      bit [62:0] value;
      bit        order_error;
    } field_result_t;

    bit [62:0]     modulus;
    bit [62:0]     root;
    field_result_t pending_results[$];
    int            mismatches;
    int            checked;
    int            mode_count[8];
    int            order_errors;

    function new();
      modulus = MODULUS_RST;
      root    = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [62:0] data);
      if (idx == CFG_MODULUS) modulus = data;
      else root = data;
    endfunction

    function void report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endfunction

    static function bit [62:0] mul_mod(bit [62:0] x, bit [62:0] y, bit [62:0] m);
      bit [125:0] prod;
      prod = 126'(x) * 126'(y);
      return 63'(prod % 126'(m));
    endfunction

    // Square-and-multiply, low exponent bit first
    static function bit [62:0] pow_mod(bit [62:0] x, bit [62:0] e, bit [62:0] m);
      bit [62:0] acc;
      bit [62:0] sq;
      acc = (m == 1) ? '0 : 63'd1;
      sq  = x;
      while (e != 0) begin
        if (e[0]) acc = mul_mod(acc, sq, m);
        sq = mul_mod(sq, sq, m);
        e  = e >> 1;
      end
      return acc;
    endfunction

    function int unsigned two_adicity();
      bit [62:0]   t;
      int unsigned n;
      t = modulus - 1;
      n = 0;
      while (t != 0 && !t[0]) begin
        n++;
        t = t >> 1;
      end
      return n;
    endfunction

    // Predict the result of one accepted operation
    function void note_op(logic [2:0] mode, bit [62:0] a_in, bit [62:0] b_in);
      field_result_t res;
      bit [63:0]     s;
      bit [62:0]     a;
      bit [62:0]     bm;
      bit [62:0]     r;
      int unsigned   adic;
      res.value       = '0;
      res.order_error = 1'b0;
      if (modulus >= 2) begin
        a = a_in % modulus;
        case (mode)
          MODE_ADD: begin
            bm = b_in % modulus;
            s  = 64'(a) + 64'(bm);
            if (s >= 64'(modulus)) s = s - 64'(modulus);
            res.value = s[62:0];
          end
          MODE_SUB: begin
            bm = b_in % modulus;
            s  = 64'(a) + ((bm == 0) ? 64'd0 : 64'(modulus - bm));
            if (s >= 64'(modulus)) s = s - 64'(modulus);
            res.value = s[62:0];
          end
          MODE_MUL: res.value = mul_mod(a, b_in % modulus, modulus);
          MODE_POW: res.value = pow_mod(a, b_in, modulus);
          MODE_INV: res.value = (a == 0) ? '0 : pow_mod(a, modulus - 2, modulus);
          MODE_ROOT: begin
            adic = two_adicity();
            if (b_in > 63'(adic)) begin
              res.order_error = 1'b1;
            end else begin
              r = root % modulus;
              repeat (adic - int'(b_in)) r = mul_mod(r, r, modulus);
              res.value = r;
            end
          end
          default: res.value = '0;
        endcase
      end
      mode_count[mode]++;
      if (res.order_error) order_errors++;
      pending_results.push_back(res);
    endfunction

    function void check_result(bit [62:0] value, bit order_error);
      field_result_t exp_res;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result value=%0d err=%0b", value, order_error));
        return;
      end
      exp_res = pending_results.pop_front();
      if (value !== exp_res.value)
        report($sformatf("result %0d value %0d, expected %0d", checked, value, exp_res.value));
      if (order_error !== exp_res.order_error)
        report($sformatf("result %0d order_error %0b, expected %0b", checked, order_error,
                         exp_res.order_error));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pfa_in_if  in_ch();
  pfa_out_if out_ch();
  pfa_cfg_if cfg_ch();

  prime_field_alu_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  field_alu_scoreboard field_sb;
  int hold_off_cycles;
  bit steady;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #200ms;
    $display("Timeout with %0d results outstanding", field_sb.pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit [62:0] rand63();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[62:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result receiver: random stalls plus a requested long hold-off
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_off_cycles--;
      end else if (steady) begin
        out_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 2);
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready && rst_n)
        field_sb.check_result(out_ch.value, out_ch.order_error);
    end
  end

  // One operation transaction; returns at a falling edge with valid still high
  task automatic send_op(logic [2:0] mode, bit [62:0] a, bit [62:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode      = mode;
    in_ch.operand_a = a;
    in_ch.operand_b = b;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    field_sb.note_op(mode, a, b);
    @(negedge clk);
  endtask

  // Wait until every expected result has arrived, then let the block settle
  task automatic drain();
    in_ch.valid = 1'b0;
    while (field_sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [62:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    field_sb.set_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic bit [62:0] pick_elem(bit [62:0] m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return (m == 0) ? ALL_ONES : m - 1;
    if (r < 18) return rand63();
    if (r < 20) return ALL_ONES;
    return (m == 0) ? rand63() : rand63() % m;
  endfunction

  // Random operations; full-size exponents are kept rare as they are slow
  task automatic run_random(int count);
    int          r;
    logic [2:0]  mode;
    bit [62:0]   a;
    bit [62:0]   b;
    int unsigned adic;
    repeat (count) begin
      r    = $urandom_range(0, 99);
      mode = (r < 15) ? MODE_ADD : (r < 30) ? MODE_SUB : (r < 50) ? MODE_MUL :
             (r < 68) ? MODE_POW : (r < 77) ? MODE_INV : (r < 95) ? MODE_ROOT :
             (r < 97) ? MODE_RSVD6 : MODE_RSVD7;
      a = pick_elem(field_sb.modulus);
      b = pick_elem(field_sb.modulus);
      if (mode == MODE_POW && $urandom_range(0, 7) != 0)
        b = 63'($urandom_range(0, 65535));
      if (mode == MODE_ROOT && $urandom_range(0, 7) != 0) begin
        adic = field_sb.two_adicity();
        b    = 63'($urandom_range(0, adic + 2));
      end
      send_op(mode, a, b);
    end
  endtask

  task automatic run_phase(bit [62:0] m, bit [62:0] root, int count);
    drain();
    write_reg(CFG_MODULUS, m);
    write_reg(CFG_ROOT, root);
    steady = ($urandom_range(0, 3) == 0);
    run_random(count);
  endtask

  // Stimulus
  initial begin
    bit [62:0] m;
    field_sb        = new();
    hold_off_cycles = 0;
    steady          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_MODULUS;
    cfg_ch.data     = '0;
    rst_n           = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (3) @(negedge clk);

    // Directed: extremes and special cases at the reset modulus
    m = MODULUS_RST;
    send_op(MODE_ADD, '0, '0);
    send_op(MODE_ADD, m - 1, m - 1);
    send_op(MODE_ADD, ALL_ONES, ALL_ONES);
    send_op(MODE_SUB, '0, m - 1);
    send_op(MODE_SUB, 63'd5, 63'd5);
    send_op(MODE_SUB, ALL_ONES, m);
    send_op(MODE_MUL, m - 1, m - 1);
    send_op(MODE_MUL, ALL_ONES, ALL_ONES);
    send_op(MODE_POW, '0, '0);
    send_op(MODE_POW, 63'd7, '0);
    send_op(MODE_POW, 63'd3, ALL_ONES);
    send_op(MODE_POW, ALL_ONES, 63'd12345);
    send_op(MODE_INV, '0, 63'd9);
    send_op(MODE_INV, 63'd2, '0);
    send_op(MODE_INV, ALL_ONES, ALL_ONES);
    send_op(MODE_ROOT, '0, '0);
    send_op(MODE_ROOT, '0, 63'd2);
    send_op(MODE_RSVD6, 63'd11, 63'd13);
    send_op(MODE_RSVD7, ALL_ONES, ALL_ONES);
    drain();
    write_reg(CFG_ROOT, ALL_ONES - 1);
    send_op(MODE_ROOT, '0, '0);
    send_op(MODE_ROOT, '0, 63'd1);
    send_op(MODE_ROOT, '0, ALL_ONES);

    // Random phases over several moduli and roots
    run_phase(63'd998244353, 63'd15311432, 70);
    // Long receiver hold-off while operations keep coming; long enough for
    // two worst-case operations, so the block is sure to fill and stall
    hold_off_cycles = 20000;
    run_random(10);
    // Sender waits for the block to empty completely
    drain();
    run_random(30);
    run_phase(63'd3, 63'd2, 50);
    run_phase(63'd17, 63'd3, 60);
    run_phase(63'd65537, 63'd3, 60);
    run_phase(MODULUS_RST, 63'd37, 60);
    run_phase(63'd9223372036854775783, rand63(), 60);
    run_phase(ALL_ONES, ALL_ONES, 40);
    run_phase(63'd1000, rand63(), 40);
    run_phase(63'd1, rand63(), 20);
    run_phase('0, '0, 20);
    run_phase(rand63() | 63'd1, rand63(), 40);
    run_phase(63'd2, 63'd1, 30);

    drain();
    repeat (200) @(posedge clk);
    $display("Checked %0d results: add %0d, sub %0d, mul %0d, pow %0d, inv %0d, root %0d",
             field_sb.checked, field_sb.mode_count[0], field_sb.mode_count[1],
             field_sb.mode_count[2], field_sb.mode_count[3], field_sb.mode_count[4],
             field_sb.mode_count[5]);
    $display("Reserved modes %0d, root order errors %0d, mismatches %0d",
             field_sb.mode_count[6] + field_sb.mode_count[7], field_sb.order_errors,
             field_sb.mismatches);
    if (field_sb.mismatches == 0 && field_sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
